>>> design/chacha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha_pkg
// shared types and constants for the seekable chacha20 stream xor block
// ----------------------------------------------------------------------------
package chacha_pkg;

    localparam int BLOCK_BYTES   = 64;
    localparam int BLOCK_WORDS   = BLOCK_BYTES / 4;
    localparam int DOUBLE_ROUNDS = 10;

    localparam logic [31:0] SIGMA_0 = 32'h61707865;
    localparam logic [31:0] SIGMA_1 = 32'h3320646e;
    localparam logic [31:0] SIGMA_2 = 32'h79622d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b206574;

    typedef logic [31:0] t_word;
    typedef t_word [15:0] t_words;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_KEY_0     = 3'd0,
        REG_KEY_1     = 3'd1,
        REG_KEY_2     = 3'd2,
        REG_KEY_3     = 3'd3,
        REG_NONCE_LO  = 3'd4,
        REG_NONCE_HI  = 3'd5,
        REG_MAX_OFF   = 3'd6
    } t_reg_idx;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_DIAG,
        ST_UNDIAG,
        ST_FINAL,
        ST_READ,
        ST_OUT
    } t_state;

endpackage

>>> design/chacha20_seekable_stream_xor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha20_seekable_stream_xor
// xors a byte stream with a chacha20 keystream starting at any byte offset
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   tdata: offset, length, byte
//                                                 tuser: first byte of request
//  m_axis    out  m_axis_tvalid / m_axis_tready   tdata: byte, tuser: refused,
//                                                 tlast: last byte of request
//  cfg       in   i_cfg_we                        i_cfg_idx, i_cfg_data
//
//  a byte inside the current keystream block goes through accept, buffer read
//  and output load; a byte that opens a block first runs keystream generation:
//  1 load, 320 quarter-round steps on one add/xor/rotate unit, 20 row permutations
//  and 16 final additions through the same adder. refused bytes bypass it to the
//  output and empty bytes are dropped. reset is synchronous, active low. the
//  output register frees the input side as soon as its byte is taken.
// ----------------------------------------------------------------------------
module chacha20_seekable_stream_xor
    import chacha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [37:0] start_offset, [76:38] request_length, [84:77] data_in, rest zero
    input  logic [87:0] s_axis_tdata,
    // [0] first_byte
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] data_out
    output logic [7:0]  m_axis_tdata,
    // [0] refused
    output logic        m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);

    // configuration
    logic [63:0] r_key0, r_key1, r_key2, r_key3, r_nonce_lo;
    logic [31:0] r_nonce_hi;
    logic [37:0] r_max_off;

    // request state
    logic [31:0] r_ctr;
    logic [5:0]  r_pos;
    logic [38:0] r_left;
    logic        r_refused;
    logic [7:0]  r_data;
    logic        r_last;

    // sequencer
    t_state      r_state, n_state;
    logic [1:0]  r_k;
    logic [1:0]  r_qr;
    logic        r_half;
    logic [3:0]  r_dr;
    logic [3:0]  r_fi;
    t_words      r_w;

    // keystream buffer
    t_word       r_ks_mem [BLOCK_WORDS];
    t_word       r_ks_q;

    // output register
    logic        r_ov;
    logic [7:0]  r_od;
    logic        r_oref;
    logic        r_olast;

    // input fields
    logic [37:0] in_off;
    logic [38:0] in_len;
    logic [7:0]  in_byte;
    logic        in_first;
    assign in_off   = s_axis_tdata[37:0];
    assign in_len   = s_axis_tdata[76:38];
    assign in_byte  = s_axis_tdata[84:77];
    assign in_first = s_axis_tuser;

    // request decode at acceptance
    logic        acc, take, empty_req, chk_ref, eff_ref, fresh;
    logic [38:0] eff_left;
    logic [37:0] room;
    assign acc       = s_axis_tvalid && s_axis_tready;
    assign eff_left  = in_first ? in_len : r_left;
    assign empty_req = (eff_left == 39'd0);
    assign take      = acc && !empty_req;
    assign room      = r_max_off - in_off;
    assign chk_ref   = (in_off > r_max_off) || ((in_len - 39'd1) > {1'b0, room});
    assign eff_ref   = in_first ? chk_ref : r_refused;
    assign fresh     = in_first && !chk_ref;

    // initial block state
    t_words init;
    always_comb begin
        init[0]  = SIGMA_0;            init[1]  = SIGMA_1;
        init[2]  = SIGMA_2;            init[3]  = SIGMA_3;
        init[4]  = r_key0[31:0];       init[5]  = r_key0[63:32];
        init[6]  = r_key1[31:0];       init[7]  = r_key1[63:32];
        init[8]  = r_key2[31:0];       init[9]  = r_key2[63:32];
        init[10] = r_key3[31:0];       init[11] = r_key3[63:32];
        init[12] = r_ctr;
        init[13] = r_nonce_lo[31:0];   init[14] = r_nonce_lo[63:32];
        init[15] = r_nonce_hi;
    end

    // shared add / xor / rotate unit
    t_word opa, opb, opx, sum, mixv, rotv;
    always_comb begin
        if (r_state == ST_FINAL) begin
            opa = r_w[0];
            opb = init[r_fi];
        end else begin
            opa = r_k[0] ? r_w[8]  : r_w[0];
            opb = r_k[0] ? r_w[12] : r_w[4];
        end
        opx  = r_k[0] ? r_w[4] : r_w[12];
        sum  = opa + opb;
        mixv = opx ^ sum;
        case (r_k)
            2'd0:    rotv = {mixv[15:0], mixv[31:16]};
            2'd1:    rotv = {mixv[19:0], mixv[31:20]};
            2'd2:    rotv = {mixv[23:0], mixv[31:24]};
            default: rotv = {mixv[24:0], mixv[31:25]};
        endcase
    end

    // round state after one step, with row rotation at the end of a quarter round
    t_words stepped, w_step, w_diag, w_undiag, w_shift;
    always_comb begin
        stepped = r_w;
        if (r_k[0]) begin
            stepped[8] = sum;
            stepped[4] = rotv;
        end else begin
            stepped[0]  = sum;
            stepped[12] = rotv;
        end
        w_step = stepped;
        if (r_k == 2'd3) begin
            for (int r = 0; r < 4; r++) begin
                for (int i = 0; i < 4; i++) begin
                    w_step[4*r + i] = stepped[4*r + ((i + 1) % 4)];
                end
            end
        end
        for (int r = 0; r < 4; r++) begin
            for (int i = 0; i < 4; i++) begin
                w_diag[4*r + i]               = r_w[4*r + ((i + r) % 4)];
                w_undiag[4*r + ((i + r) % 4)] = r_w[4*r + i];
            end
        end
        for (int j = 0; j < 16; j++) begin
            w_shift[j] = r_w[(j + 1) % 16];
        end
    end

    logic last_step, last_dr, final_done;
    assign last_step  = (r_k == 2'd3) && (r_qr == 2'd3);
    assign last_dr    = (r_dr == 4'(DOUBLE_ROUNDS - 1));
    assign final_done = (r_fi == 4'(BLOCK_WORDS - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (take && !eff_ref) begin
                    n_state = (fresh || r_pos == 6'd0) ? ST_LOAD : ST_READ;
                end
            end
            ST_LOAD:   n_state = ST_ROUND;
            ST_ROUND: begin
                if (last_step) begin
                    n_state = r_half ? ST_UNDIAG : ST_DIAG;
                end
            end
            ST_DIAG:   n_state = ST_ROUND;
            ST_UNDIAG: n_state = last_dr ? ST_FINAL : ST_ROUND;
            ST_FINAL:  n_state = final_done ? ST_READ : ST_FINAL;
            ST_READ:   n_state = ST_OUT;
            ST_OUT:    n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // handshake outputs
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE) && (!r_ov || m_axis_tready);
    end
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;
    assign m_axis_tuser  = r_oref;
    assign m_axis_tlast  = r_olast;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0 <= '0; r_key1 <= '0; r_key2 <= '0; r_key3 <= '0;
            r_nonce_lo <= '0; r_nonce_hi <= '0;
            r_max_off <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_KEY_0:    r_key0     <= i_cfg_data;
                REG_KEY_1:    r_key1     <= i_cfg_data;
                REG_KEY_2:    r_key2     <= i_cfg_data;
                REG_KEY_3:    r_key3     <= i_cfg_data;
                REG_NONCE_LO: r_nonce_lo <= i_cfg_data;
                REG_NONCE_HI: r_nonce_hi <= i_cfg_data[31:0];
                REG_MAX_OFF:  r_max_off  <= i_cfg_data[37:0];
                default: ;
            endcase
        end
    end

    // keystream buffer write and read
    always_ff @(posedge i_clk) begin
        if (r_state == ST_FINAL) begin
            r_ks_mem[r_fi] <= sum;
        end
        if (r_state == ST_READ) begin
            r_ks_q <= r_ks_mem[r_pos[5:2]];
        end
    end

    // round state and loop counters
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_LOAD:   r_w <= init;
            ST_ROUND:  r_w <= w_step;
            ST_DIAG:   r_w <= w_diag;
            ST_UNDIAG: r_w <= w_undiag;
            ST_FINAL:  r_w <= w_shift;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0; r_qr <= '0; r_half <= 1'b0; r_dr <= '0; r_fi <= '0;
        end else begin
            case (r_state)
                ST_LOAD: begin
                    r_k <= '0; r_qr <= '0; r_half <= 1'b0; r_dr <= '0; r_fi <= '0;
                end
                ST_ROUND: begin
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd3) r_qr <= r_qr + 2'd1;
                end
                ST_DIAG:   r_half <= 1'b1;
                ST_UNDIAG: begin
                    r_half <= 1'b0;
                    r_dr   <= r_dr + 4'd1;
                end
                ST_FINAL:  r_fi <= r_fi + 4'd1;
                default: ;
            endcase
        end
    end

    // request state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr <= '0; r_pos <= '0; r_left <= '0; r_refused <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (r_ov && m_axis_tready) r_ov <= 1'b0;
            if (acc) begin
                if (in_first) r_refused <= chk_ref;
                if (empty_req) begin
                    r_left <= '0;
                end else begin
                    r_left <= eff_left - 39'd1;
                    if (fresh) begin
                        r_ctr <= in_off[37:6];
                        r_pos <= in_off[5:0];
                    end
                    if (eff_ref) begin
                        r_ov <= 1'b1;
                    end
                end
            end
            if (r_state == ST_OUT) begin
                r_ov  <= 1'b1;
                r_pos <= r_pos + 6'd1;
                if (r_pos == 6'd63) r_ctr <= r_ctr + 32'd1;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_data  <= in_byte;
            r_last  <= (eff_left == 39'd1);
            r_od    <= in_byte;
            r_oref  <= eff_ref;
            r_olast <= (eff_left == 39'd1);
        end
        if (r_state == ST_OUT) begin
            r_od    <= r_data ^ r_ks_q[8*r_pos[1:0] +: 8];
            r_oref  <= 1'b0;
            r_olast <= r_last;
        end
    end

endmodule

>>> design/chacha_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha_checker
// port-level checks for the seekable chacha20 stream xor block
// ----------------------------------------------------------------------------
module chacha_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // stalled output transaction holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // no input transaction while a result is stuck at the output
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !(s_axis_tvalid && s_axis_tready))
        else $error("input taken while output stalled");

    // reset leaves no result pending
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind chacha20_seekable_stream_xor chacha_checker u_chacha_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
